>>> rtl/core/cqs_pkg.sv
// Shared types and constants for the circular queue with search.
// Holds request and status codes, the control state type and the cell control struct.
// No dependencies.
package cqs_pkg;

  localparam int WORD_W = 32;
  localparam int SLOT_W = 4;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic tok_load;
    logic tok_shift;
  } cell_ctl_t;

endpackage

>>> rtl/core/circular_queue_with_search_top.sv
// Circular queue of signed 32-bit words with insert, delete and search requests.
// Insert, delete, empty search: result registered in the execute state once the output is free.
// Other searches: the token moves one cell per cycle from the head while the output is free.
// One item is in work at a time; a new item is accepted while the previous result waits.
// Reset clears the pointers, occupancy, search tokens and output valid; slot words are not cleared.
// Depends on cqs_pkg, cqs_ctrl and cqs_cell.
module circular_queue_with_search_top
  import cqs_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] word_in
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] word_out, [35:32] slot_found, [39:36] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  cell_ctl_t                cell_ctl;
  logic [DEPTH-1:0]         head_oh;
  logic [DEPTH-1:0]         tail_oh;
  logic [DEPTH-1:0]         tok;
  logic [DEPTH-1:0]         hit;
  logic signed [WORD_W-1:0] rd_word [DEPTH];
  logic signed [WORD_W-1:0] key;
  logic signed [WORD_W-1:0] head_word;
  logic                     hit_any;
  status_t                  out_status;
  logic signed [WORD_W-1:0] out_word;
  logic [SLOT_W-1:0]        out_slot;

  cqs_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (req_t'(s_tuser)),
    .in_word    (s_tdata),
    .hit_any    (hit_any),
    .head_word  (head_word),
    .cell_ctl   (cell_ctl),
    .head_oh    (head_oh),
    .tail_oh    (tail_oh),
    .key        (key),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_word   (out_word),
    .out_slot   (out_slot)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int PREV = (i + DEPTH - 1) % DEPTH;
    cqs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl),
      .wr_sel   (tail_oh[i]),
      .head_sel (head_oh[i]),
      .wr_data  (key),
      .key      (key),
      .tok_in   (tok[PREV]),
      .tok_out  (tok[i]),
      .hit      (hit[i]),
      .rd_word  (rd_word[i])
    );
  end

  always_comb begin
    head_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      head_word = head_word | rd_word[i];
    end
  end

  assign hit_any = |hit;

  assign m_tdata = {4'b0000, out_slot, out_word};
  assign m_tuser = out_status;

endmodule

>>> rtl/core/cqs_cell.sv
// One queue slot: stores a word and carries the search token to its neighbor.
// Depends on cqs_pkg for the word width and the cell control struct.
module cqs_cell
  import cqs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctl_t                ctl,
  input  logic                     wr_sel,
  input  logic                     head_sel,
  input  logic signed [WORD_W-1:0] wr_data,
  input  logic signed [WORD_W-1:0] key,
  input  logic                     tok_in,
  output logic                     tok_out,
  output logic                     hit,
  output logic signed [WORD_W-1:0] rd_word
);

  logic signed [WORD_W-1:0] word;
  logic                     token;
  logic                     token_next;

  always_comb begin
    token_next = token;
    if (ctl.tok_load) begin
      token_next = head_sel;
    end else if (ctl.tok_shift) begin
      token_next = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else begin
      token <= token_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_sel) begin
      word <= wr_data;
    end
  end

  assign tok_out = token;
  assign hit     = token && (word == key);
  assign rd_word = head_sel ? word : '0;

endmodule

>>> rtl/core/cqs_ctrl.sv
// Queue controller: head, tail and occupancy, request sequencing and the result register.
// Depends on cqs_pkg; drives the row of cqs_cell slots through the cell control struct.
module cqs_ctrl
  import cqs_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  req_t                     in_req,
  input  logic signed [WORD_W-1:0] in_word,
  input  logic                     hit_any,
  input  logic signed [WORD_W-1:0] head_word,
  output cell_ctl_t                cell_ctl,
  output logic [DEPTH-1:0]         head_oh,
  output logic [DEPTH-1:0]         tail_oh,
  output logic signed [WORD_W-1:0] key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output status_t                  out_status,
  output logic signed [WORD_W-1:0] out_word,
  output logic [SLOT_W-1:0]        out_slot
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t          state;
  state_t          state_next;
  req_t            req;
  logic [IW-1:0]   head;
  logic [IW-1:0]   tail;
  logic [IW-1:0]   pos;
  logic [CW-1:0]   occ;
  logic [CW-1:0]   step;
  logic            out_free;
  logic            is_full;
  logic            is_empty;
  logic            last_step;
  logic            do_insert;
  logic            do_delete;
  logic            scan_start;
  logic            scan_adv;
  logic            load_result;
  status_t         res_status;
  logic signed [WORD_W-1:0] res_word;
  logic [SLOT_W-1:0] res_slot;
  logic [IW:0]     pos_plus1;

  assign out_free  = !out_valid || out_ready;
  assign is_full   = (occ == CW'(DEPTH));
  assign is_empty  = (occ == '0);
  assign last_step = (CW'(step + CW'(1)) == occ);
  assign in_ready  = (state == S_IDLE);
  assign pos_plus1 = (IW + 1)'(pos) + (IW + 1)'(1);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      head_oh[i] = (head == IW'(i));
      tail_oh[i] = (tail == IW'(i));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req)
          REQ_INSERT, REQ_DELETE: begin
            if (out_free) begin
              state_next = S_IDLE;
            end
          end
          REQ_SEARCH: begin
            if (!is_empty) begin
              state_next = S_SCAN;
            end else if (out_free) begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (out_free && (hit_any || last_step)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    scan_start  = 1'b0;
    scan_adv    = 1'b0;
    load_result = 1'b0;
    res_status  = ST_OK;
    res_word    = '0;
    res_slot    = '0;
    case (state)
      S_EXEC: begin
        case (req)
          REQ_INSERT: begin
            if (out_free) begin
              load_result = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                do_insert = 1'b1;
              end
            end
          end
          REQ_DELETE: begin
            if (out_free) begin
              load_result = 1'b1;
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                do_delete = 1'b1;
                res_word  = head_word;
              end
            end
          end
          REQ_SEARCH: begin
            if (!is_empty) begin
              scan_start = 1'b1;
            end else if (out_free) begin
              load_result = 1'b1;
              res_status  = ST_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (out_free) begin
          if (hit_any) begin
            load_result = 1'b1;
            res_slot    = SLOT_W'(pos_plus1);
          end else if (last_step) begin
            load_result = 1'b1;
            res_status  = ST_NOTFOUND;
          end else begin
            scan_adv = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cell_ctl.wr_en     = do_insert;
  assign cell_ctl.tok_load  = scan_start;
  assign cell_ctl.tok_shift = scan_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      step      <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_insert) begin
        tail <= (tail == IW'(DEPTH - 1)) ? '0 : IW'(tail + IW'(1));
        occ  <= CW'(occ + CW'(1));
      end
      if (do_delete) begin
        occ <= CW'(occ - CW'(1));
        if (occ == CW'(1)) begin
          head <= '0;
          tail <= '0;
        end else begin
          head <= (head == IW'(DEPTH - 1)) ? '0 : IW'(head + IW'(1));
        end
      end
      if (scan_start) begin
        step <= '0;
        pos  <= head;
      end else if (scan_adv) begin
        step <= CW'(step + CW'(1));
        pos  <= (pos == IW'(DEPTH - 1)) ? '0 : IW'(pos + IW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_req;
      key <= in_word;
    end
    if (load_result) begin
      out_status <= res_status;
      out_word   <= res_word;
      out_slot   <= res_slot;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy exceeds queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (head == '0 && tail == '0))
    else $error("pointers not at slot zero while queue is empty");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !is_empty)
    else $error("search scan running on an empty queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_status) && $stable(out_word)
                                   && $stable(out_slot)))
    else $error("pending result overwritten");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (step < occ))
    else $error("search scan ran past the occupied entries");
`endif

endmodule
